### sv/ray_box_slab_intersect_top_assert.svh
// Assertion macros for the ray versus box slab test.
// Included by the top level; no other dependencies.
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define RBS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rbs assertion failed");

// next-cycle implication, checked out of reset
`define RBS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rbs assertion failed");

`endif

### sv/rbs_pkg.sv
// Shared types and constants for the ray versus box slab test.
// No dependencies.
`timescale 1ns / 1ps

package rbs_pkg;

    localparam int W          = 32;          // Q16.16 word width
    localparam int NUM_W      = W + 1;       // bound minus origin magnitude
    localparam int EPS_W      = 17;          // near limit width
    localparam int FRAC_W     = 16;          // fraction bits
    localparam int DIV_STEPS  = 4;           // quotient bits per divider stage
    localparam int DIV_STAGES = W / DIV_STEPS;
    localparam int DIV_LAT    = DIV_STAGES + 2;  // input reg, stages, output reg
    localparam int AXES       = 3;
    localparam int IDX_W      = 3;

    localparam logic signed [W-1:0] SAT_MAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] SAT_MIN = {1'b1, {(W-1){1'b0}}};

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_MIN_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_MIN_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_MAX_X = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_Y = 3'd4;
    localparam logic [IDX_W-1:0] REG_MAX_Z = 3'd5;
    localparam logic [IDX_W-1:0] REG_NEAR  = 3'd6;

    // ray data carried alongside the dividers
    typedef struct packed {
        logic [AXES-1:0][W-1:0] org;
        logic [AXES-1:0][W-1:0] dir;
        logic [AXES-1:0]        dneg;
        logic [AXES-1:0]        dzero;
        logic                   miss;
    } t_side;

endpackage

### sv/rbs_div.sv
// Pipelined restoring divider: saturated Q16.16 quotient of magnitudes.
// Uses rbs_pkg.
`timescale 1ns / 1ps

module rbs_div (
    input  logic                           i_clk,
    input  logic                           i_ce,
    input  logic [rbs_pkg::NUM_W-1:0]      i_num_mag,
    input  logic [rbs_pkg::W-1:0]          i_den_mag,
    input  logic                           i_neg,
    output logic signed [rbs_pkg::W-1:0]   o_quo
);

    localparam int W  = rbs_pkg::W;
    localparam int FW = rbs_pkg::FRAC_W;
    localparam int NS = rbs_pkg::DIV_STAGES;
    localparam int HI = rbs_pkg::NUM_W - FW;   // integer part bits of numerator

    logic [W-1:0] r_rem  [0:NS];
    logic [W-1:0] r_feed [0:NS];
    logic [W-1:0] r_q    [0:NS];
    logic [W-1:0] r_den  [0:NS];
    logic         r_ovf  [0:NS];
    logic         r_neg  [0:NS];
    logic signed [W-1:0] r_quo;
    logic signed [W-1:0] n_quo;

    // entry: quotient >= 2^32 when the scaled numerator's top reaches or exceeds the divisor
    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_ovf[0]  <= {{(W-HI){1'b0}}, i_num_mag[rbs_pkg::NUM_W-1:FW]} >= i_den_mag;
            r_rem[0]  <= {{(W-HI){1'b0}}, i_num_mag[rbs_pkg::NUM_W-1:FW]};
            r_feed[0] <= {i_num_mag[FW-1:0], {(W-FW){1'b0}}};
            r_q[0]    <= '0;
            r_den[0]  <= i_den_mag;
            r_neg[0]  <= i_neg;
        end
    end

    // iteration stages, DIV_STEPS quotient bits each
    for (genvar k = 1; k <= NS; k++) begin : g_stage
        logic [W-1:0] n_rem, n_feed, n_q;
        always_comb begin
            logic [W:0] trial;
            n_rem  = r_rem[k-1];
            n_feed = r_feed[k-1];
            n_q    = r_q[k-1];
            for (int j = 0; j < rbs_pkg::DIV_STEPS; j++) begin
                trial  = {n_rem, n_feed[W-1]};
                n_feed = {n_feed[W-2:0], 1'b0};
                if (trial >= {1'b0, r_den[k-1]}) begin
                    trial = trial - {1'b0, r_den[k-1]};
                    n_q   = {n_q[W-2:0], 1'b1};
                end else begin
                    n_q   = {n_q[W-2:0], 1'b0};
                end
                n_rem = trial[W-1:0];
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[k]  <= n_rem;
                r_feed[k] <= n_feed;
                r_q[k]    <= n_q;
                r_den[k]  <= r_den[k-1];
                r_ovf[k]  <= r_ovf[k-1];
                r_neg[k]  <= r_neg[k-1];
            end
        end
    end

    // sign and saturate
    always_comb begin
        if (r_ovf[NS] || r_q[NS][W-1]) begin
            n_quo = r_neg[NS] ? rbs_pkg::SAT_MIN : rbs_pkg::SAT_MAX;
        end else begin
            n_quo = r_neg[NS] ? -$signed(r_q[NS]) : $signed(r_q[NS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_quo <= n_quo;
        end
    end

    assign o_quo = r_quo;

endmodule

### sv/ray_box_slab_intersect_top.sv
// Ray versus axis-aligned box slab test, top level.
// Uses rbs_pkg, rbs_div and ray_box_slab_intersect_top_assert.svh.
//
//  channel | direction | handshake            | words
//  ray     | in        | i_valid / o_ready    | origin_x/y/z, dir_x/y/z
//  result  | out       | o_valid / i_ready    | is_hit, distance, point_x/y/z
//  config  | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// One ray per cycle while the result side is not stalled; 14 register stages:
// front stage, dividers (input reg, 8 stages of 4 quotient bits, output reg), combine,
// multiply, out.
// A stall on the result side freezes every stage at once; nothing is dropped.
// Reset (synchronous, active low) clears the valid bits, the box registers and the near limit.
`timescale 1ns / 1ps

`include "ray_box_slab_intersect_top_assert.svh"

module ray_box_slab_intersect_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [rbs_pkg::W-1:0]  i_origin_x,
    input  logic signed [rbs_pkg::W-1:0]  i_origin_y,
    input  logic signed [rbs_pkg::W-1:0]  i_origin_z,
    input  logic signed [rbs_pkg::W-1:0]  i_dir_x,
    input  logic signed [rbs_pkg::W-1:0]  i_dir_y,
    input  logic signed [rbs_pkg::W-1:0]  i_dir_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_is_hit,
    output logic signed [rbs_pkg::W-1:0]  o_distance,
    output logic signed [rbs_pkg::W-1:0]  o_point_x,
    output logic signed [rbs_pkg::W-1:0]  o_point_y,
    output logic signed [rbs_pkg::W-1:0]  o_point_z,
    input  logic                          i_cfg_we,
    input  logic [rbs_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [rbs_pkg::W-1:0]         i_cfg_data
);

    localparam int W  = rbs_pkg::W;
    localparam int NW = rbs_pkg::NUM_W;
    localparam int NA = rbs_pkg::AXES;
    localparam int DL = rbs_pkg::DIV_LAT;
    localparam int PW = 2 * W;
    localparam int SW = PW - rbs_pkg::FRAC_W;

    logic [W-1:0]               r_box_lo [0:NA-1];
    logic [W-1:0]               r_box_hi [0:NA-1];
    logic [rbs_pkg::EPS_W-1:0]  r_eps;

    logic ce;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < NA; a++) begin
                r_box_lo[a] <= '0;
                r_box_hi[a] <= '0;
            end
            r_eps <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rbs_pkg::REG_MIN_X: r_box_lo[0] <= i_cfg_data;
                rbs_pkg::REG_MIN_Y: r_box_lo[1] <= i_cfg_data;
                rbs_pkg::REG_MIN_Z: r_box_lo[2] <= i_cfg_data;
                rbs_pkg::REG_MAX_X: r_box_hi[0] <= i_cfg_data;
                rbs_pkg::REG_MAX_Y: r_box_hi[1] <= i_cfg_data;
                rbs_pkg::REG_MAX_Z: r_box_hi[2] <= i_cfg_data;
                rbs_pkg::REG_NEAR:  r_eps <= i_cfg_data[rbs_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // global advance: the whole pipe moves unless the output word is stuck
    assign ce      = !o_valid || i_ready;
    assign o_ready = ce;

    // front stage: slab offsets, magnitudes and signs
    logic [W-1:0]  w_org [0:NA-1];
    logic [W-1:0]  w_dir [0:NA-1];
    assign w_org[0] = i_origin_x;
    assign w_org[1] = i_origin_y;
    assign w_org[2] = i_origin_z;
    assign w_dir[0] = i_dir_x;
    assign w_dir[1] = i_dir_y;
    assign w_dir[2] = i_dir_z;

    logic [NW-1:0]  n_f_mlo [0:NA-1];
    logic [NW-1:0]  n_f_mhi [0:NA-1];
    logic [NA-1:0]  n_f_nlo, n_f_nhi;
    logic [W-1:0]   n_f_den [0:NA-1];
    rbs_pkg::t_side n_f_side;

    always_comb begin
        logic signed [NW-1:0] dlo, dhi;
        n_f_side      = '0;
        for (int a = 0; a < NA; a++) begin
            dlo = $signed({r_box_lo[a][W-1], r_box_lo[a]}) - $signed({w_org[a][W-1], w_org[a]});
            dhi = $signed({r_box_hi[a][W-1], r_box_hi[a]}) - $signed({w_org[a][W-1], w_org[a]});
            n_f_mlo[a] = dlo[NW-1] ? NW'(-dlo) : NW'(dlo);
            n_f_mhi[a] = dhi[NW-1] ? NW'(-dhi) : NW'(dhi);
            n_f_nlo[a] = dlo[NW-1] ^ w_dir[a][W-1];
            n_f_nhi[a] = dhi[NW-1] ^ w_dir[a][W-1];
            n_f_den[a] = w_dir[a][W-1] ? W'(-$signed(w_dir[a])) : w_dir[a];
            n_f_side.org[a]   = w_org[a];
            n_f_side.dir[a]   = w_dir[a];
            n_f_side.dneg[a]  = w_dir[a][W-1];
            n_f_side.dzero[a] = (w_dir[a] == '0);
            if ((w_dir[a] == '0) &&
                (($signed(w_org[a]) < $signed(r_box_lo[a])) ||
                 ($signed(w_org[a]) > $signed(r_box_hi[a])))) begin
                n_f_side.miss = 1'b1;
            end
        end
    end

    logic [NW-1:0]  r_f_mlo [0:NA-1];
    logic [NW-1:0]  r_f_mhi [0:NA-1];
    logic [NA-1:0]  r_f_nlo, r_f_nhi;
    logic [W-1:0]   r_f_den [0:NA-1];
    rbs_pkg::t_side r_f_side;
    logic           r_f_vld;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < NA; a++) begin
                r_f_mlo[a] <= n_f_mlo[a];
                r_f_mhi[a] <= n_f_mhi[a];
                r_f_den[a] <= n_f_den[a];
            end
            r_f_nlo  <= n_f_nlo;
            r_f_nhi  <= n_f_nhi;
            r_f_side <= n_f_side;
        end
    end

    // six dividers: both planes of each axis
    logic signed [W-1:0] w_qlo [0:NA-1];
    logic signed [W-1:0] w_qhi [0:NA-1];

    for (genvar a = 0; a < NA; a++) begin : g_axis
        rbs_div u_div_lo (
            .i_clk     (i_clk),
            .i_ce      (ce),
            .i_num_mag (r_f_mlo[a]),
            .i_den_mag (r_f_den[a]),
            .i_neg     (r_f_nlo[a]),
            .o_quo     (w_qlo[a])
        );
        rbs_div u_div_hi (
            .i_clk     (i_clk),
            .i_ce      (ce),
            .i_num_mag (r_f_mhi[a]),
            .i_den_mag (r_f_den[a]),
            .i_neg     (r_f_nhi[a]),
            .o_quo     (w_qhi[a])
        );
    end

    // ray data rides along with the dividers
    rbs_pkg::t_side r_side [0:DL-1];
    logic           r_d_vld [0:DL-1];

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_side[0] <= r_f_side;
            for (int k = 1; k < DL; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // combine: largest entry, smallest exit, hit test and chosen distance
    logic                signed [W:0] w_eps33;
    logic                n_c1_hit;
    logic signed [W-1:0] n_c1_t;
    assign w_eps33 = $signed({{(W+1-rbs_pkg::EPS_W){1'b0}}, r_eps});

    always_comb begin
        logic signed [W-1:0] t0, t1, tin, tout;
        t0 = rbs_pkg::SAT_MIN;
        t1 = rbs_pkg::SAT_MAX;
        for (int a = 0; a < NA; a++) begin
            tin  = r_side[DL-1].dneg[a] ? w_qhi[a] : w_qlo[a];
            tout = r_side[DL-1].dneg[a] ? w_qlo[a] : w_qhi[a];
            if (!r_side[DL-1].dzero[a]) begin
                if (tin > t0) t0 = tin;
                if (tout < t1) t1 = tout;
            end
        end
        n_c1_hit = !r_side[DL-1].miss && (t0 < t1) &&
                   ($signed({t1[W-1], t1}) > w_eps33);
        n_c1_t   = ($signed({t0[W-1], t0}) > w_eps33) ? t0 : t1;
    end

    logic                r_c1_vld, r_c1_hit;
    logic signed [W-1:0] r_c1_t;
    rbs_pkg::t_side      r_c1_side;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_c1_hit  <= n_c1_hit;
            r_c1_t    <= n_c1_t;
            r_c1_side <= r_side[DL-1];
        end
    end

    // multiply: distance times each direction component
    logic signed [PW-1:0] r_c2_p [0:NA-1];
    logic                 r_c2_vld, r_c2_hit;
    logic signed [W-1:0]  r_c2_t;
    logic [NA-1:0][W-1:0] r_c2_org;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            for (int a = 0; a < NA; a++) begin
                r_c2_p[a] <= PW'(r_c1_t) * PW'($signed(r_c1_side.dir[a]));
            end
            r_c2_hit <= r_c1_hit;
            r_c2_t   <= r_c1_t;
            r_c2_org <= r_c1_side.org;
        end
    end

    // output: floor shift, add origin, saturate, zero on a miss
    logic signed [W-1:0] n_pt [0:NA-1];

    always_comb begin
        logic signed [SW-1:0] sum;
        for (int a = 0; a < NA; a++) begin
            sum = SW'($signed(r_c2_org[a])) + $signed(r_c2_p[a][PW-1:rbs_pkg::FRAC_W]);
            if (!r_c2_hit) begin
                n_pt[a] = '0;
            end else if (sum > SW'(rbs_pkg::SAT_MAX)) begin
                n_pt[a] = rbs_pkg::SAT_MAX;
            end else if (sum < SW'(rbs_pkg::SAT_MIN)) begin
                n_pt[a] = rbs_pkg::SAT_MIN;
            end else begin
                n_pt[a] = sum[W-1:0];
            end
        end
    end

    logic                r_o_vld, r_o_hit;
    logic signed [W-1:0] r_o_dist, r_o_px, r_o_py, r_o_pz;

    always_ff @(posedge i_clk) begin
        if (ce) begin
            r_o_hit  <= r_c2_hit;
            r_o_dist <= r_c2_hit ? r_c2_t : '0;
            r_o_px   <= n_pt[0];
            r_o_py   <= n_pt[1];
            r_o_pz   <= n_pt[2];
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld  <= 1'b0;
            for (int k = 0; k < DL; k++) begin
                r_d_vld[k] <= 1'b0;
            end
            r_c1_vld <= 1'b0;
            r_c2_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else if (ce) begin
            r_f_vld    <= i_valid;
            r_d_vld[0] <= r_f_vld;
            for (int k = 1; k < DL; k++) begin
                r_d_vld[k] <= r_d_vld[k-1];
            end
            r_c1_vld <= r_d_vld[DL-1];
            r_c2_vld <= r_c1_vld;
            r_o_vld  <= r_c2_vld;
        end
    end

    assign o_valid    = r_o_vld;
    assign o_is_hit   = r_o_hit;
    assign o_distance = r_o_dist;
    assign o_point_x  = r_o_px;
    assign o_point_y  = r_o_py;
    assign o_point_z  = r_o_pz;

    // checks
    logic w_all_zero, w_dist_far;
    assign w_all_zero = (o_distance == '0) && (o_point_x == '0) &&
                        (o_point_y == '0) && (o_point_z == '0);
    assign w_dist_far = $signed({o_distance[W-1], o_distance}) > w_eps33;

    `RBS_ASSERT_IMP(a_miss_zero, i_clk, i_rst_n, o_valid && !o_is_hit, w_all_zero)
    `RBS_ASSERT_IMP(a_hit_beyond_eps, i_clk, i_rst_n, o_valid && o_is_hit, w_dist_far)
    `RBS_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && o_ready, r_f_vld)

endmodule
